// ===== hw/rtl/hsv_to_rgb_converter_assert.svh =====
// Assertion macros for the HSV to RGB converter.
// No dependencies; included by the top level only.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HSVC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hsvc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define HSVC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hsvc: next-cycle check failed");

`endif

// ===== hw/rtl/hsvc_pkg.sv =====
// Shared types and constants for the HSV to RGB converter.
// No dependencies.
`default_nettype none

package hsvc_pkg;

    // Hue sector, 60 degrees each.
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    localparam int NUM_SECTORS = 6;

    // p = floor(x / 255) for x < 2^16: x * ceil(2^24 / 255) >> 24
    localparam int P_DIV   = 255;
    localparam int P_SHIFT = 24;
    localparam int P_RECIP_W = 17;
    localparam longint unsigned P_RECIP_L = ((64'd1 << P_SHIFT) + P_DIV - 1) / P_DIV;
    localparam logic [P_RECIP_W-1:0] P_RECIP = P_RECIP_L[P_RECIP_W-1:0];

    // q, t: numerator is pre-shifted by the power-of-two factor of the
    // denominator, leaving a 20-bit value to divide by 3825.
    localparam int QSH_W   = 20;
    localparam int Q_DIV   = 3825;
    localparam int Q_SHIFT = 32;
    localparam int Q_RECIP_W = 21;
    localparam longint unsigned Q_RECIP_L = ((64'd1 << Q_SHIFT) + Q_DIV - 1) / Q_DIV;
    localparam logic [Q_RECIP_W-1:0] Q_RECIP = Q_RECIP_L[Q_RECIP_W-1:0];

    // Into the reciprocal stage.
    typedef struct packed {
        sector_t          sector;
        logic [7:0]       v;
        logic [7:0]       alpha;
        logic [7:0]       p;
        logic [QSH_W-1:0] qn;
        logic [QSH_W-1:0] tn;
    } quot_in_t;

    // Into the channel ordering stage.
    typedef struct packed {
        sector_t    sector;
        logic [7:0] v;
        logic [7:0] alpha;
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
    } chan_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hsvc_sector_stage.sv =====
// Stage 1: hue wrap, sector and remainder within the sector.
// Depends on hsvc_pkg.
`default_nettype none

module hsvc_sector_stage
    import hsvc_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 6,
    parameter int REM_W = 12
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [14:0]      hue,
    input  wire logic [7:0]       sat,
    input  wire logic [7:0]       val,
    input  wire logic [7:0]       alpha,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output sector_t               sector,
    output logic [REM_W-1:0]      rem,
    output logic [7:0]            sat_o,
    output logic [7:0]            val_o,
    output logic [7:0]            alpha_o
);

    localparam int HUE_EXT_W = 17;
    localparam int SECT      = 60 << HUE_FRAC_BITS;
    localparam int HUE_FULL  = 360 << HUE_FRAC_BITS;

    logic [HUE_EXT_W-1:0] hue_ext;
    logic [HUE_EXT_W-1:0] base;
    sector_t              sector_next;
    logic                 valid_reg;
    sector_t              sector_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [7:0]           sat_reg, val_reg, alpha_reg;

    always_comb begin
        hue_ext = {2'b00, hue};
        if (hue_ext >= HUE_EXT_W'(HUE_FULL)) begin
            hue_ext = '0;
        end
        sector_next = SEC_RED_YEL;
        base        = '0;
        // independent compares against the sector boundaries
        for (int k = 1; k < NUM_SECTORS; k++) begin
            if (hue_ext >= HUE_EXT_W'(k * SECT)) begin
                sector_next = sector_t'(3'(k));
                base        = HUE_EXT_W'(k * SECT);
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sector_reg <= sector_next;
            rem_reg    <= REM_W'(hue_ext - base);
            sat_reg    <= sat;
            val_reg    <= val;
            alpha_reg  <= alpha;
        end
    end

    assign out_valid = valid_reg;
    assign sector    = sector_reg;
    assign rem       = rem_reg;
    assign sat_o     = sat_reg;
    assign val_o     = val_reg;
    assign alpha_o   = alpha_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hsvc_product_stage.sv =====
// Stages 2 and 3: saturation products, then brightness products and p.
// Depends on hsvc_pkg.
`default_nettype none

module hsvc_product_stage
    import hsvc_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 6,
    parameter int REM_W = 12
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire sector_t          sector,
    input  wire logic [REM_W-1:0] rem,
    input  wire logic [7:0]       sat,
    input  wire logic [7:0]       val,
    input  wire logic [7:0]       alpha,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output quot_in_t              out_data
);

    localparam int SECT  = 60 << HUE_FRAC_BITS;
    localparam int DENOM = 255 * SECT;
    localparam int D_W   = $clog2(DENOM + 1);
    localparam int SP_W  = 8 + REM_W;
    localparam int QN_W  = 8 + D_W;
    localparam int PP_W  = 16 + P_RECIP_W;

    // stage 2
    logic             v2_reg;
    logic             rdy2;
    sector_t          sector2_reg;
    logic [7:0]       val2_reg, alpha2_reg;
    logic [SP_W-1:0]  srem_reg, stail_reg;
    logic [15:0]      pn_reg;

    // stage 3
    logic             v3_reg;
    logic             rdy3;
    quot_in_t         q3_reg;

    logic [D_W-1:0]   qdiff, tdiff;
    logic [QN_W-1:0]  qprod, tprod;
    logic [PP_W-1:0]  pprod;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy2) begin
                v2_reg <= in_valid;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && in_valid) begin
            sector2_reg <= sector;
            val2_reg    <= val;
            alpha2_reg  <= alpha;
            srem_reg    <= SP_W'(sat) * SP_W'(rem);
            stail_reg   <= SP_W'(sat) * SP_W'(REM_W'(SECT) - rem);
            pn_reg      <= 16'(val) * 16'(8'd255 - sat);
        end
    end

    always_comb begin
        qdiff = D_W'(DENOM) - D_W'(srem_reg);
        tdiff = D_W'(DENOM) - D_W'(stail_reg);
        qprod = QN_W'(val2_reg) * QN_W'(qdiff);
        tprod = QN_W'(val2_reg) * QN_W'(tdiff);
        pprod = PP_W'(pn_reg) * PP_W'(P_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            q3_reg.sector <= sector2_reg;
            q3_reg.v      <= val2_reg;
            q3_reg.alpha  <= alpha2_reg;
            q3_reg.p      <= pprod[P_SHIFT +: 8];
            // strip the 2^(frac+2) factor of the denominator
            q3_reg.qn     <= qprod[HUE_FRAC_BITS+2 +: QSH_W];
            q3_reg.tn     <= tprod[HUE_FRAC_BITS+2 +: QSH_W];
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = q3_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hsvc_divide_stage.sv =====
// Stage 4: q and t by reciprocal multiplication with 3825.
// Depends on hsvc_pkg.
`default_nettype none

module hsvc_divide_stage
    import hsvc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire quot_in_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output chan_t         out_data
);

    localparam int QP_W = QSH_W + Q_RECIP_W;

    logic        valid_reg;
    chan_t       data_reg;
    logic [QP_W-1:0] qprod, tprod;

    assign qprod    = QP_W'(in_data.qn) * QP_W'(Q_RECIP);
    assign tprod    = QP_W'(in_data.tn) * QP_W'(Q_RECIP);
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg.sector <= in_data.sector;
            data_reg.v      <= in_data.v;
            data_reg.alpha  <= in_data.alpha;
            data_reg.p      <= in_data.p;
            data_reg.q      <= qprod[Q_SHIFT +: 8];
            data_reg.t      <= tprod[Q_SHIFT +: 8];
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hsvc_order_stage.sv =====
// Stage 5: sector ordering of v, p, q, t onto RGB; output register.
// Depends on hsvc_pkg.
`default_nettype none

module hsvc_order_stage
    import hsvc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire chan_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic [7:0] alpha
);

    logic       valid_reg;
    logic [7:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic [7:0] red_next, green_next, blue_next;

    always_comb begin
        case (in_data.sector)
            SEC_RED_YEL: begin
                red_next = in_data.v; green_next = in_data.t; blue_next = in_data.p;
            end
            SEC_YEL_GRN: begin
                red_next = in_data.q; green_next = in_data.v; blue_next = in_data.p;
            end
            SEC_GRN_CYN: begin
                red_next = in_data.p; green_next = in_data.v; blue_next = in_data.t;
            end
            SEC_CYN_BLU: begin
                red_next = in_data.p; green_next = in_data.q; blue_next = in_data.v;
            end
            SEC_BLU_MAG: begin
                red_next = in_data.t; green_next = in_data.p; blue_next = in_data.v;
            end
            default: begin
                red_next = in_data.v; green_next = in_data.p; blue_next = in_data.q;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= in_data.alpha;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign alpha     = alpha_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hsv_to_rgb_converter.sv =====
// Top level of the HSV to RGB converter: five-stage pipeline.
// Depends on hsvc_pkg, the hsvc_* stage modules and the assertion header.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-----------------------------------------
//   s_      | in        | s_valid / s_ready  | hue[15], saturation, brightness, alpha_in
//   m_      | out       | m_valid / m_ready  | red, green, blue, alpha_out
//
// One pixel per clock sustained while m_ready stays high; a result is registered in
// every stage in turn, the last being the output register.
// Stages: sector compare, saturation products, brightness products (with p),
// reciprocal divide for q and t, sector ordering into the output register.
// Each stage has its own valid bit; ready ripples back stage by stage, so
// bubbles close up while the output is stalled and nothing is dropped or repeated.
// Synchronous active-low reset clears the valid bits only.
`default_nettype none

`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter
    import hsvc_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 6
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [14:0] s_hue,
    input  wire logic [7:0]  s_saturation,
    input  wire logic [7:0]  s_brightness,
    input  wire logic [7:0]  s_alpha_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_red,
    output logic [7:0]       m_green,
    output logic [7:0]       m_blue,
    output logic [7:0]       m_alpha_out
);

    // Remainder within a sector runs 0 .. (60 << frac) - 1.
    localparam int REM_W = $clog2(60 << HUE_FRAC_BITS);

    // stage 1 -> 2
    logic             sec_valid, sec_ready;
    sector_t          sec_sector;
    logic [REM_W-1:0] sec_rem;
    logic [7:0]       sec_sat, sec_val, sec_alpha;

    // stage 3 -> 4
    logic             prod_valid, prod_ready;
    quot_in_t         prod_data;

    // stage 4 -> 5
    logic             div_valid, div_ready;
    chan_t            div_data;

    hsvc_sector_stage #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .REM_W         (REM_W)
    ) u_sector (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .hue       (s_hue),
        .sat       (s_saturation),
        .val       (s_brightness),
        .alpha     (s_alpha_in),
        .out_valid (sec_valid),
        .out_ready (sec_ready),
        .sector    (sec_sector),
        .rem       (sec_rem),
        .sat_o     (sec_sat),
        .val_o     (sec_val),
        .alpha_o   (sec_alpha)
    );

    // two register stages inside: s*rem products and v*(255 - s), then v*(D - ...) and p
    hsvc_product_stage #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .REM_W         (REM_W)
    ) u_product (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sec_valid),
        .in_ready  (sec_ready),
        .sector    (sec_sector),
        .rem       (sec_rem),
        .sat       (sec_sat),
        .val       (sec_val),
        .alpha     (sec_alpha),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    hsvc_divide_stage u_divide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    hsvc_order_stage u_order (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   (div_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .red       (m_red),
        .green     (m_green),
        .blue      (m_blue),
        .alpha     (m_alpha_out)
    );

    // Input is refused only with every visible stage boundary holding a pixel.
    `HSVC_ASSERT_IMPL(a_stall_only_when_full, aclk, aresetn, !s_ready,
                      sec_valid && prod_valid && div_valid && m_valid)
    // An input transfer always lands in the first stage.
    `HSVC_ASSERT_NEXT(a_accept_lands, aclk, aresetn, s_valid && s_ready, sec_valid)
    // A result taken with nothing behind it leaves the output empty.
    `HSVC_ASSERT_NEXT(a_no_invented_result, aclk, aresetn,
                      m_valid && m_ready && !div_valid, !m_valid)

endmodule

`default_nettype wire

// ===== sim/hsv_to_rgb_converter_checker.sv =====
// Scoreboard for the HSV to RGB converter: watches both channels, predicts each pixel.
// Depends on hsvc_pkg for the hue sector type.
`default_nettype none

module hsv_to_rgb_converter_checker
    import hsvc_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 6
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [14:0] s_hue,
    input  wire logic [7:0]  s_saturation,
    input  wire logic [7:0]  s_brightness,
    input  wire logic [7:0]  s_alpha_in,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [7:0]  m_red,
    input  wire logic [7:0]  m_green,
    input  wire logic [7:0]  m_blue,
    input  wire logic [7:0]  m_alpha_out,
    output int               mismatches,
    output int               pixels_pending,
    output int               pixels_checked
);

    localparam longint unsigned SECT_W   = 64'd60 << HUE_FRAC_BITS;
    localparam longint unsigned HUE_WRAP = 64'd360 << HUE_FRAC_BITS;
    localparam longint unsigned QT_DIV   = 64'd255 * SECT_W;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    pixel_t expected_pixels[$];

    function automatic pixel_t predict_pixel(input logic [14:0] hue, input logic [7:0] sat,
                                             input logic [7:0] val, input logic [7:0] alpha);
        longint unsigned h, rem, s, v, p, q, t;
        logic [2:0]      sidx;
        sector_t         sect;
        pixel_t          px;
        h = hue;
        if (h >= HUE_WRAP)
            h = 0;                      // full turn or beyond reads as red
        sidx = 3'(h / SECT_W);
        sect = sector_t'(sidx);
        rem  = h % SECT_W;
        s    = sat;
        v    = val;
        p    = (v * (64'd255 - s)) / 64'd255;
        q    = (v * (QT_DIV - s * rem)) / QT_DIV;
        t    = (v * (QT_DIV - s * (SECT_W - rem))) / QT_DIV;
        px.alpha = alpha;
        case (sect)
            SEC_RED_YEL: begin px.red = v[7:0]; px.green = t[7:0]; px.blue = p[7:0]; end
            SEC_YEL_GRN: begin px.red = q[7:0]; px.green = v[7:0]; px.blue = p[7:0]; end
            SEC_GRN_CYN: begin px.red = p[7:0]; px.green = v[7:0]; px.blue = t[7:0]; end
            SEC_CYN_BLU: begin px.red = p[7:0]; px.green = q[7:0]; px.blue = v[7:0]; end
            SEC_BLU_MAG: begin px.red = t[7:0]; px.green = p[7:0]; px.blue = v[7:0]; end
            default:     begin px.red = v[7:0]; px.green = p[7:0]; px.blue = q[7:0]; end
        endcase
        return px;
    endfunction

    // Sampled at the edge, before the driver's nonblocking updates land.
    always @(posedge aclk) begin
        pixel_t exp_px;
        if (!aresetn) begin
            expected_pixels.delete();
            mismatches     = 0;
            pixels_pending = 0;
            pixels_checked = 0;
        end else begin
            if (s_valid && s_ready)
                expected_pixels.push_back(predict_pixel(s_hue, s_saturation,
                                                        s_brightness, s_alpha_in));
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result transfer r=%0d g=%0d b=%0d a=%0d",
                             $time, m_red, m_green, m_blue, m_alpha_out);
                    mismatches++;
                end else begin
                    exp_px = expected_pixels.pop_front();
                    pixels_checked++;
                    if (m_red !== exp_px.red) begin
                        $display("%0t: red expected %0d actual %0d",
                                 $time, exp_px.red, m_red);
                        mismatches++;
                    end
                    if (m_green !== exp_px.green) begin
                        $display("%0t: green expected %0d actual %0d",
                                 $time, exp_px.green, m_green);
                        mismatches++;
                    end
                    if (m_blue !== exp_px.blue) begin
                        $display("%0t: blue expected %0d actual %0d",
                                 $time, exp_px.blue, m_blue);
                        mismatches++;
                    end
                    if (m_alpha_out !== exp_px.alpha) begin
                        $display("%0t: alpha expected %0d actual %0d",
                                 $time, exp_px.alpha, m_alpha_out);
                        mismatches++;
                    end
                end
            end
            pixels_pending = expected_pixels.size();
        end
    end

endmodule

`default_nettype wire

// ===== sim/hsv_to_rgb_converter_tb.sv =====
// Testbench top for the HSV to RGB converter: clock, reset, pixel stimulus and verdict.
// Depends on hsvc_pkg, the converter RTL and hsv_to_rgb_converter_checker.
`default_nettype none

module hsv_to_rgb_converter_tb;

    localparam int HUE_FRAC_BITS = 6;
    localparam int SECT_W        = 60 << HUE_FRAC_BITS;   // 3840
    localparam int HUE_WRAP      = 360 << HUE_FRAC_BITS;  // 23040
    localparam int HUE_MAX       = 32767;
    localparam int RANDOM_PIXELS = 1030;
    localparam int CALM_FROM     = 880;     // no new idling started on either side from here on
    localparam int CYCLE_LIMIT   = 200000;
    localparam int TAIL_CYCLES   = 10;      // five-stage pipe, plus margin

    // Everything the converter sees is known from time zero.
    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic [14:0] s_hue        = '0;
    logic [7:0]  s_saturation = '0;
    logic [7:0]  s_brightness = '0;
    logic [7:0]  s_alpha_in   = '0;
    logic        m_ready      = 1'b0;

    logic        s_ready;
    logic        m_valid;
    logic [7:0]  m_red, m_green, m_blue, m_alpha_out;

    int          mismatches, pixels_pending, pixels_checked;
    int          cycle_count   = 0;
    int          wrapped_sent  = 0;
    int          grey_sent     = 0;
    bit          calm          = 1'b0;

    always #5 aclk = ~aclk;

    hsv_to_rgb_converter #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_hue       (s_hue),
        .s_saturation(s_saturation),
        .s_brightness(s_brightness),
        .s_alpha_in  (s_alpha_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue),
        .m_alpha_out (m_alpha_out)
    );

    hsv_to_rgb_converter_checker #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_hue         (s_hue),
        .s_saturation  (s_saturation),
        .s_brightness  (s_brightness),
        .s_alpha_in    (s_alpha_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_alpha_out   (m_alpha_out),
        .mismatches    (mismatches),
        .pixels_pending(pixels_pending),
        .pixels_checked(pixels_checked)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d pixels still outstanding",
                     cycle_count, pixels_pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side back-pressure: random stall bursts, none started once calm.
    // Exactly one nonblocking write to m_ready per edge.
    always @(posedge aclk) begin
        int stall_left;
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            m_ready    <= 1'b0;
            stall_left = $urandom_range(1, 12) - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // One pixel transfer. Called just after a rising edge; returns just after the
    // edge that took the pixel. Ready is looked at mid-cycle, where it is settled,
    // so the wait never races the converter's own register updates.
    task automatic send_pixel(input logic [14:0] hue, input logic [7:0] sat,
                              input logic [7:0] val, input logic [7:0] alpha);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_hue        <= hue;
        s_saturation <= sat;
        s_brightness <= val;
        s_alpha_in   <= alpha;
        if (hue >= HUE_WRAP)
            wrapped_sent++;
        if (sat == 8'd0)
            grey_sent++;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Sender holds off until the pipe has handed back every pixel it took.
    task automatic drain_pipe();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pixels_pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Bytes lean on the extremes now and then.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Hue: mostly in range, some at or past a full turn, some hugging sector edges.
    function automatic logic [14:0] pick_hue();
        int edge_hue;
        case ($urandom_range(0, 9))
            0:       return 15'($urandom_range(HUE_WRAP, HUE_MAX));
            1: begin
                edge_hue = $urandom_range(0, 6) * SECT_W + $urandom_range(0, 2) - 1;
                if (edge_hue < 0)
                    edge_hue = 0;
                return 15'(edge_hue);
            end
            default: return 15'($urandom_range(0, HUE_WRAP - 1));
        endcase
    endfunction

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: every sector, several sector edges, the wrap point, top of the hue
        // field, grey, black, full scale and the alpha extremes.
        send_pixel(15'd0,                8'd255, 8'd255, 8'd0);
        send_pixel(15'(SECT_W - 1),      8'd255, 8'd255, 8'd255);
        send_pixel(15'(SECT_W),          8'd255, 8'd255, 8'd17);
        send_pixel(15'(2 * SECT_W - 1),  8'd200, 8'd180, 8'd128);
        send_pixel(15'(2 * SECT_W),      8'd255, 8'd255, 8'd1);
        send_pixel(15'(3 * SECT_W + 7),  8'd128, 8'd255, 8'd254);
        send_pixel(15'(4 * SECT_W),      8'd255, 8'd100, 8'd85);
        send_pixel(15'(5 * SECT_W + 1),  8'd255, 8'd255, 8'd170);
        send_pixel(15'(HUE_WRAP - 1),    8'd255, 8'd255, 8'd255);
        send_pixel(15'(HUE_WRAP),        8'd255, 8'd255, 8'd0);
        send_pixel(15'(HUE_WRAP + 1),    8'd180, 8'd90,  8'd33);
        send_pixel(15'(HUE_MAX),         8'd255, 8'd255, 8'd255);
        send_pixel(15'd16384,            8'd77,  8'd201, 8'd66);
        send_pixel(15'(SECT_W / 2),      8'd0,   8'd255, 8'd99);
        send_pixel(15'(3 * SECT_W),      8'd0,   8'd123, 8'd200);
        send_pixel(15'd12345,            8'd0,   8'd0,   8'd0);
        send_pixel(15'd6000,             8'd255, 8'd0,   8'd255);
        send_pixel(15'd9000,             8'd1,   8'd1,   8'd3);
        send_pixel(15'd20000,            8'd254, 8'd254, 8'd252);
        send_pixel(15'd1000,             8'd255, 8'd1,   8'd12);

        // Let the directed pixels come out before the random traffic starts.
        drain_pipe();

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if (i == CALM_FROM)
                calm = 1'b1;
            if (!calm && $urandom_range(0, 199) == 0)
                drain_pipe();
            send_pixel(pick_hue(), pick_byte(), pick_byte(), pick_byte());
        end

        drain_pipe();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Checked %0d pixels in %0d cycles: all six sectors and their edges,",
                 pixels_checked, cycle_count);
        $display("%0d hues at or past a full turn, %0d grey pixels, idling on both sides",
                 wrapped_sent, grey_sent);
        if (mismatches == 0 && pixels_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/hsvc_pkg.sv
hw/rtl/hsvc_sector_stage.sv
hw/rtl/hsvc_product_stage.sv
hw/rtl/hsvc_divide_stage.sv
hw/rtl/hsvc_order_stage.sv
hw/rtl/hsv_to_rgb_converter.sv
sim/hsv_to_rgb_converter_checker.sv
sim/hsv_to_rgb_converter_tb.sv
